// File: design/bc1_pkg.sv
// Shared types and constants for the BC1 block decoder.
// Used by the front, queue, back and top-level files; depends on nothing else.
package bc1_pkg;

  localparam int ROWS_PER_BLOCK = 4;
  localparam int TEXELS_PER_ROW = 4;
  localparam int PALETTE_SIZE   = 4;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [1:0]  LAST_ROW_NUM = 2'd3;
  // floor(x / 3) == (x * 683) >> 11 for every x up to 765.
  localparam logic [9:0]  RECIP3       = 10'd683;
  localparam int          RECIP3_SHIFT = 11;

  typedef struct packed {
    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [31:0] texel_indices;
  } item_t;

  typedef struct packed {
    logic [1:0]  row_number;
    logic        last_row;
    logic [31:0] texel_0;
    logic [31:0] texel_1;
    logic [31:0] texel_2;
    logic [31:0] texel_3;
  } result_t;

  typedef struct packed {
    logic [PALETTE_SIZE-1:0][31:0] palette;
    logic [31:0]                   texel_indices;
  } q_entry_t;

endpackage

// File: design/bc1_front.sv
// Front stage: expands the endpoints and builds the four-entry RGBA8 palette.
// Depends on bc1_pkg; feeds bc1_queue.
module bc1_front import bc1_pkg::*; (
  input  item_t    item,
  output q_entry_t entry
);

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = x * RECIP3;
    div3 = prod[RECIP3_SHIFT +: 8];
  endfunction

  logic [2:0][7:0] e0;
  logic [2:0][7:0] e1;
  logic [2:0][7:0] m2;
  logic [2:0][7:0] m3;
  logic            four_color;
  logic [9:0]      s_a;
  logic [9:0]      s_b;
  logic [8:0]      s_avg;

  assign e0[0] = widen5(item.color_a[15:11]);
  assign e0[1] = widen6(item.color_a[10:5]);
  assign e0[2] = widen5(item.color_a[4:0]);
  assign e1[0] = widen5(item.color_b[15:11]);
  assign e1[1] = widen6(item.color_b[10:5]);
  assign e1[2] = widen5(item.color_b[4:0]);

  assign four_color = item.color_a > item.color_b;

  always_comb begin
    s_a   = '0;
    s_b   = '0;
    s_avg = '0;
    for (int k = 0; k < 3; k++) begin
      s_a   = {1'b0, e0[k], 1'b0} + {2'b00, e1[k]};
      s_b   = {2'b00, e0[k]} + {1'b0, e1[k], 1'b0};
      s_avg = {1'b0, e0[k]} + {1'b0, e1[k]};
      if (four_color) begin
        m2[k] = div3(s_a);
        m3[k] = div3(s_b);
      end else begin
        m2[k] = s_avg[8:1];
        m3[k] = 8'd0;
      end
    end
  end

  always_comb begin
    entry.texel_indices = item.texel_indices;
    entry.palette[0]    = {ALPHA_OPAQUE, e0[2], e0[1], e0[0]};
    entry.palette[1]    = {ALPHA_OPAQUE, e1[2], e1[1], e1[0]};
    entry.palette[2]    = {ALPHA_OPAQUE, m2[2], m2[1], m2[0]};
    entry.palette[3]    = {(four_color ? ALPHA_OPAQUE : 8'd0), m3[2], m3[1], m3[0]};
  end

endmodule

// File: design/bc1_queue.sv
// Short queue of decoded palettes between the front and back stages.
// Depends on bc1_pkg for the entry type.
module bc1_queue import bc1_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd,
  output q_entry_t rd_data,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            wr_en;
  logic            rd_en;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_en   = wr && !full;
  assign rd_en   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

// File: design/bc1_back.sv
// Back stage: walks the four texel rows of the queued block and holds each
// row in an output register until it is taken. Depends on bc1_pkg.
module bc1_back import bc1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t head,
  input  logic     head_empty,
  output logic     head_pop,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic [1:0]  row;
  logic        out_valid;
  logic        load;
  logic [7:0]  row_idx;
  result_t     row_beat;

  assign load     = !head_empty && (!out_valid || pop);
  assign head_pop = load && (row == LAST_ROW_NUM);
  assign empty    = !out_valid;
  assign row_idx  = head.texel_indices[{row, 3'b000} +: 8];

  always_comb begin
    row_beat.row_number = row;
    row_beat.last_row   = (row == LAST_ROW_NUM);
    row_beat.texel_0    = head.palette[row_idx[1:0]];
    row_beat.texel_1    = head.palette[row_idx[3:2]];
    row_beat.texel_2    = head.palette[row_idx[5:4]];
    row_beat.texel_3    = head.palette[row_idx[7:6]];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= row_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        row       <= row + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/bc1_block_decoder.sv
// BC1 (DXT1) block decoder, top level.
// Instantiates bc1_front, bc1_queue and bc1_back; depends on bc1_pkg.
//
// Input channel: one beat is one compressed block (two RGB565 endpoints and
// sixteen 2-bit indices). A beat is taken on a rising edge with push high and
// full low. The front builds the palette in the same cycle and writes it to a
// QUEUE_DEPTH-entry queue; full reflects that queue.
// Result channel: each block yields four beats, one texel row each, top row
// first, with last_row set on the fourth. The oldest row is on result while
// empty is low and is taken on an edge with pop high.
// A block taken by an empty decoder goes into the queue, then its first row
// is loaded into the output register. Throughput: one row per cycle while pop
// is high and a block is queued, set by the single output register.
// When pop is held low the output register holds its row, the queue fills,
// and full then rises; nothing is dropped. Reset (rst, synchronous) empties
// the queue and the output register and restarts the row count at zero.
module bc1_block_decoder import bc1_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  q_entry_t front_entry;
  q_entry_t head;
  logic     head_empty;
  logic     head_pop;

  bc1_front u_front (
    .item  (item),
    .entry (front_entry)
  );

  bc1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_entry),
    .full    (full),
    .rd      (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  bc1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
